FILE: hdl/md5h_pkg.sv
package md5h_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5h_words_t;

  localparam logic [31:0] MD5H_INIT_A = 32'h67452301;
  localparam logic [31:0] MD5H_INIT_B = 32'hefcdab89;
  localparam logic [31:0] MD5H_INIT_C = 32'h98badcfe;
  localparam logic [31:0] MD5H_INIT_D = 32'h10325476;

  localparam logic [7:0] MD5H_PAD_BYTE  = 8'h80;
  localparam logic [5:0] MD5H_LEN_START = 6'd56;
  localparam logic [5:0] MD5H_LAST_BYTE = 6'd63;
  localparam logic [5:0] MD5H_LAST_RND  = 6'd63;

  localparam md5h_words_t MD5H_INIT = '{
    a: MD5H_INIT_A, b: MD5H_INIT_B, c: MD5H_INIT_C, d: MD5H_INIT_D
  };

  function automatic logic [3:0] md5h_msg_index(input logic [5:0] rnd);
    logic [3:0] lo;
    lo = rnd[3:0];
    unique case (rnd[5:4])
      2'd0: return lo;
      2'd1: return 4'd5 * lo + 4'd1;
      2'd2: return 4'd3 * lo + 4'd5;
      2'd3: return 4'd7 * lo;
      default: return lo;
    endcase
  endfunction

  function automatic logic [4:0] md5h_rot_amount(input logic [5:0] rnd);
    unique case ({rnd[5:4], rnd[1:0]})
      4'd0:  return 5'd7;
      4'd1:  return 5'd12;
      4'd2:  return 5'd17;
      4'd3:  return 5'd22;
      4'd4:  return 5'd5;
      4'd5:  return 5'd9;
      4'd6:  return 5'd14;
      4'd7:  return 5'd20;
      4'd8:  return 5'd4;
      4'd9:  return 5'd11;
      4'd10: return 5'd16;
      4'd11: return 5'd23;
      4'd12: return 5'd6;
      4'd13: return 5'd10;
      4'd14: return 5'd15;
      4'd15: return 5'd21;
      default: return 5'd7;
    endcase
  endfunction

  function automatic logic [31:0] md5h_round_const(input logic [5:0] rnd);
    unique case (rnd)
      6'd0:  return 32'hd76aa478;
      6'd1:  return 32'he8c7b756;
      6'd2:  return 32'h242070db;
      6'd3:  return 32'hc1bdceee;
      6'd4:  return 32'hf57c0faf;
      6'd5:  return 32'h4787c62a;
      6'd6:  return 32'ha8304613;
      6'd7:  return 32'hfd469501;
      6'd8:  return 32'h698098d8;
      6'd9:  return 32'h8b44f7af;
      6'd10: return 32'hffff5bb1;
      6'd11: return 32'h895cd7be;
      6'd12: return 32'h6b901122;
      6'd13: return 32'hfd987193;
      6'd14: return 32'ha679438e;
      6'd15: return 32'h49b40821;
      6'd16: return 32'hf61e2562;
      6'd17: return 32'hc040b340;
      6'd18: return 32'h265e5a51;
      6'd19: return 32'he9b6c7aa;
      6'd20: return 32'hd62f105d;
      6'd21: return 32'h02441453;
      6'd22: return 32'hd8a1e681;
      6'd23: return 32'he7d3fbc8;
      6'd24: return 32'h21e1cde6;
      6'd25: return 32'hc33707d6;
      6'd26: return 32'hf4d50d87;
      6'd27: return 32'h455a14ed;
      6'd28: return 32'ha9e3e905;
      6'd29: return 32'hfcefa3f8;
      6'd30: return 32'h676f02d9;
      6'd31: return 32'h8d2a4c8a;
      6'd32: return 32'hfffa3942;
      6'd33: return 32'h8771f681;
      6'd34: return 32'h6d9d6122;
      6'd35: return 32'hfde5380c;
      6'd36: return 32'ha4beea44;
      6'd37: return 32'h4bdecfa9;
      6'd38: return 32'hf6bb4b60;
      6'd39: return 32'hbebfbc70;
      6'd40: return 32'h289b7ec6;
      6'd41: return 32'heaa127fa;
      6'd42: return 32'hd4ef3085;
      6'd43: return 32'h04881d05;
      6'd44: return 32'hd9d4d039;
      6'd45: return 32'he6db99e5;
      6'd46: return 32'h1fa27cf8;
      6'd47: return 32'hc4ac5665;
      6'd48: return 32'hf4292244;
      6'd49: return 32'h432aff97;
      6'd50: return 32'hab9423a7;
      6'd51: return 32'hfc93a039;
      6'd52: return 32'h655b59c3;
      6'd53: return 32'h8f0ccc92;
      6'd54: return 32'hffeff47d;
      6'd55: return 32'h85845dd1;
      6'd56: return 32'h6fa87e4f;
      6'd57: return 32'hfe2ce6e0;
      6'd58: return 32'ha3014314;
      6'd59: return 32'h4e0811a1;
      6'd60: return 32'hf7537e82;
      6'd61: return 32'hbd3af235;
      6'd62: return 32'h2ad7d2bb;
      6'd63: return 32'heb86d391;
      default: return 32'hd76aa478;
    endcase
  endfunction

endpackage

FILE: hdl/md5h_ram.sv
module md5h_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

FILE: hdl/md5h_round.sv
module md5h_round import md5h_pkg::*; (
  input  md5h_words_t work,
  input  logic [31:0] msg_word,
  input  logic [5:0]  rnd,
  output logic [31:0] b_new
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] dbl;

  always_comb begin
    unique case (rnd[5:4])
      2'd0: f = (work.b & work.c) | (~work.b & work.d);
      2'd1: f = (work.b & work.d) | (work.c & ~work.d);
      2'd2: f = work.b ^ work.c ^ work.d;
      2'd3: f = work.c ^ (work.b | ~work.d);
      default: f = '0;
    endcase
    sum   = work.a + f + md5h_round_const(rnd) + msg_word;
    dbl   = {sum, sum} << md5h_rot_amount(rnd);
    b_new = work.b + dbl[63:32];
  end

endmodule

FILE: hdl/md5_stream_hasher.sv
// MD5 digest over a byte stream.
// Input channel: one item per message byte (in_has_byte high) or an empty
// end marker (in_has_byte low). An item with in_end_of_message high closes
// the message after its byte, if any, and produces exactly one result item
// carrying the 128-bit digest as four little-endian words A, B, C and D.
// A plain byte item is written straight into the block buffer. Every 64th
// byte starts a compression (a load step, 64 rounds on the shared round
// unit, a fold step), and no bytes are taken until it is done.
// At end of message the padding bytes are written one per cycle, followed by
// one or two compressions, before the digest is offered. in_ready is low
// while padding or compressing.
// The digest sits in an output register; the block accepts the bytes of the
// next message while it waits, and only stalls before a second digest if
// the first one has not yet been taken.
// Reset (synchronous, active low) loads the MD5 initial chaining words,
// clears the bit count and the fill position and drops out_valid.
module md5_stream_hasher import md5h_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word_a,
  output logic [31:0] out_digest_word_b,
  output logic [31:0] out_digest_word_c,
  output logic [31:0] out_digest_word_d
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PAD    = 6'b000010,
    S_PREP   = 6'b000100,
    S_ROUND  = 6'b001000,
    S_FOLD   = 6'b010000,
    S_DIGEST = 6'b100000
  } state_t;

  state_t      state_r, state_nxt;
  md5h_words_t chain_r, chain_nxt;
  md5h_words_t work_r, work_nxt;
  md5h_words_t out_r, out_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic        pad_r, pad_nxt;
  logic        pad80_r, pad80_nxt;
  logic        spill_r, spill_nxt;
  logic        final_r, final_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic        ram_we;
  logic [7:0]  ram_wdata;
  logic [3:0]  ram_raddr;
  logic [7:0]  lane_rdata [4];
  logic [31:0] msg_word;
  logic [31:0] b_new;

  assign in_ready = (state_r == S_IDLE);
  assign msg_word = {lane_rdata[3], lane_rdata[2], lane_rdata[1], lane_rdata[0]};

  for (genvar i = 0; i < 4; i++) begin : g_lane
    md5h_ram #(
      .WIDTH(8),
      .DEPTH(16)
    ) u_lane (
      .clk    (clk),
      .wr_en  (ram_we && (fill_r[1:0] == 2'(i))),
      .wr_addr(fill_r[5:2]),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(lane_rdata[i])
    );
  end

  md5h_round u_round (
    .work    (work_r),
    .msg_word(msg_word),
    .rnd     (rnd_r),
    .b_new   (b_new)
  );

  always_comb begin
    state_nxt     = state_r;
    chain_nxt     = chain_r;
    work_nxt      = work_r;
    out_nxt       = out_r;
    bits_nxt      = bits_r;
    fill_nxt      = fill_r;
    rnd_nxt       = rnd_r;
    pad_nxt       = pad_r;
    pad80_nxt     = pad80_r;
    spill_nxt     = spill_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_wdata     = in_data_byte;
    ram_raddr     = md5h_msg_index(rnd_r + 6'd1);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_has_byte) begin
            ram_we   = 1'b1;
            fill_nxt = fill_r + 6'd1;
            bits_nxt = bits_r + 64'd8;
          end
          if (in_end_of_message) begin
            pad_nxt   = 1'b1;
            pad80_nxt = 1'b1;
          end
          if (in_has_byte && (fill_r == MD5H_LAST_BYTE)) begin
            state_nxt = S_PREP;
          end else if (in_end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        ram_we    = 1'b1;
        fill_nxt  = fill_r + 6'd1;
        pad80_nxt = 1'b0;
        if (pad80_r) begin
          ram_wdata = MD5H_PAD_BYTE;
          // No room for the length in this block, so it goes into one more.
          if (fill_r >= MD5H_LEN_START) begin
            spill_nxt = 1'b1;
          end
        end else if ((fill_r < MD5H_LEN_START) || spill_r) begin
          ram_wdata = 8'h00;
        end else begin
          ram_wdata = bits_r[{fill_r[2:0], 3'b000} +: 8];
        end
        if (fill_r == MD5H_LAST_BYTE) begin
          state_nxt = S_PREP;
          spill_nxt = 1'b0;
          if (!pad80_r && !spill_r) begin
            final_nxt = 1'b1;
          end
        end
      end
      S_PREP: begin
        work_nxt  = chain_r;
        rnd_nxt   = '0;
        ram_raddr = md5h_msg_index('0);
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        work_nxt = '{a: work_r.d, b: b_new, c: work_r.b, d: work_r.c};
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == MD5H_LAST_RND) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        chain_nxt.a = chain_r.a + work_r.a;
        chain_nxt.b = chain_r.b + work_r.b;
        chain_nxt.c = chain_r.c + work_r.c;
        chain_nxt.d = chain_r.d + work_r.d;
        priority if (final_r) begin
          state_nxt = S_DIGEST;
        end else if (pad_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIGEST: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = chain_r;
          out_valid_nxt = 1'b1;
          chain_nxt     = MD5H_INIT;
          bits_nxt      = '0;
          fill_nxt      = '0;
          pad_nxt       = 1'b0;
          pad80_nxt     = 1'b0;
          spill_nxt     = 1'b0;
          final_nxt     = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chain_r     <= MD5H_INIT;
      bits_r      <= '0;
      fill_r      <= '0;
      rnd_r       <= '0;
      pad_r       <= 1'b0;
      pad80_r     <= 1'b0;
      spill_r     <= 1'b0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chain_r     <= chain_nxt;
      bits_r      <= bits_nxt;
      fill_r      <= fill_nxt;
      rnd_r       <= rnd_nxt;
      pad_r       <= pad_nxt;
      pad80_r     <= pad80_nxt;
      spill_r     <= spill_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_digest_word_a = out_r.a;
  assign out_digest_word_b = out_r.b;
  assign out_digest_word_c = out_r.c;
  assign out_digest_word_d = out_r.d;

endmodule

FILE: hdl/md5h_checker.sv
module md5h_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_data_byte,
  input logic        in_has_byte,
  input logic        in_end_of_message,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word_a,
  input logic [31:0] out_digest_word_b,
  input logic [31:0] out_digest_word_c,
  input logic [31:0] out_digest_word_d
);

  // A waiting input item must stay offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data_byte)
      && $stable(in_has_byte) && $stable(in_end_of_message))
    else $error("input item changed or dropped while waiting");

  // A stalled digest must stay offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word_a)
      && $stable(out_digest_word_b) && $stable(out_digest_word_c)
      && $stable(out_digest_word_d))
    else $error("digest item changed or dropped while stalled");

  // Closing a message starts padding or a compression, so the block must go busy.
  a_busy_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_message |=> !in_ready)
    else $error("block still ready right after an end of message");

  // A digest is only produced from the busy phase, never straight from intake.
  a_digest_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("digest appeared while the block was taking bytes");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear the output and return to intake");

endmodule

bind md5_stream_hasher md5h_checker u_md5h_checker (.*);
